// ===== hdl/fba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg: shared types and codes of the frame bitmap allocator
// Request and response payloads, command and status codes, and the
// control bundle between controller and datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int PF_W    = 12;        // page frame / frame index width
    localparam int FIU_W   = 13;        // frames_in_use register width
    localparam int RECIP_W = PF_W + 2;  // reciprocal width for frame -> word split

    localparam int DEF_FRAME_COUNT   = 4096;
    localparam int DEF_BITS_PER_WORD = 32;

    localparam logic [FIU_W-1:0] FIU_RESET = 13'd4096;

    // request commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_TEST  = 2'd2;

    // response status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [PF_W-1:0] page_frame;
        logic            kernel_access;
        logic            write_access;
    } fba_req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [PF_W-1:0] frame_index;
        logic            present;
        logic            writeable;
        logic            user_mode;
        logic            frame_used;
    } fba_rsp_t;

    // which response the datapath builds
    typedef enum logic [2:0] {
        RES_NONE,
        RES_HELD,
        RES_ALLOC,
        RES_FULL,
        RES_FREE,
        RES_TEST
    } res_kind_t;

    typedef struct packed {
        logic      load_item;
        logic      scan_start;
        logic      scan_step;
        logic      div_step;
        logic      fetch;
        logic      sample_bit;
        logic      wr_alloc;
        logic      wr_free;
        logic      res_load;
        res_kind_t res_kind;
    } fba_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       pf_zero;
        logic       pf_in_map;
        logic       hit;
        logic       scan_done;
    } fba_stat_t;

endpackage

// ===== hdl/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: physical frame allocator over a used-bit map
// Allocate with page frame zero takes the lowest clear bit among the managed
// frames, free clears a nonzero frame's bit, test reports it.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   s_      | in        | s_valid / s_ready  | fba_req_t  (one request)
//   m_      | out       | m_valid / m_ready  | fba_rsp_t  (one response)
//   cfg_    | in        | cfg_wr_en          | frames_in_use (13 bits)
//
// The scan reads one bitmap word per cycle through the single read port of
// the bitmap RAM.
// One request is in flight; the next is taken in the cycle after the response
// is loaded, even while that response still waits on m_ready.
// Reset clears per-word valid bits at once (no clearing pass); words never
// written read as all free. frames_in_use returns to 4096.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int FRAME_COUNT   = fba_pkg::DEF_FRAME_COUNT,
    parameter int BITS_PER_WORD = fba_pkg::DEF_BITS_PER_WORD
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [fba_pkg::FIU_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  fba_pkg::fba_req_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fba_pkg::fba_rsp_t         m_data
);

    import fba_pkg::*;

    fba_cmd_t  ctl_cmd;
    fba_stat_t dp_stat;

    // sequencer: owns request/response handshakes and steps the datapath
    fba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (ctl_cmd)
    );

    // bitmap RAM, scanner, frame split and response register
    fba_datapath #(
        .FRAME_COUNT   (FRAME_COUNT),
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (ctl_cmd),
        .stat        (dp_stat),
        .m_data      (m_data)
    );

    // a taken request holds off the next one until its response is loaded
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("request taken while another is in flight");

    // a response only appears as the sequencer returns to idle
    a_rsp_at_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready
    ) else $error("response raised outside the finish step");

    // no response can be produced in the cycle right after a request
    a_no_instant_rsp: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid || $past(m_valid))
    ) else $error("response appeared without processing");

    // a tested bit is only reported on a completed test
    a_used_only_on_test: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_used) |-> (m_data.status == ST_DONE && !m_data.present)
    ) else $error("frame_used set on a non-test response");

endmodule

// ===== hdl/fba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/fba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_datapath: bitmap storage, word scanner and response builder
// Holds the used-bit map in RAM with per-word valid bits, scans for the
// lowest clear bit one word per cycle and does read-modify-write updates.
// ----------------------------------------------------------------------------
module fba_datapath #(
    parameter int FRAME_COUNT   = fba_pkg::DEF_FRAME_COUNT,
    parameter int BITS_PER_WORD = fba_pkg::DEF_BITS_PER_WORD
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [fba_pkg::FIU_W-1:0]  cfg_wr_data,
    input  fba_pkg::fba_req_t          s_data,
    input  fba_pkg::fba_cmd_t          cmd,
    output fba_pkg::fba_stat_t         stat,
    output fba_pkg::fba_rsp_t          m_data
);

    import fba_pkg::*;

    localparam int WORDS     = (FRAME_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WB        = $clog2(BITS_PER_WORD);
    localparam int BASE_W    = $clog2(FRAME_COUNT + 1);
    localparam int CMP_W     = ((BASE_W > FIU_W) ? BASE_W : FIU_W) + 1;
    localparam int LIMIT_MAX = (FRAME_COUNT / BITS_PER_WORD) * BITS_PER_WORD;
    localparam int SHIFT     = PF_W + WB;
    localparam int PROD_W    = PF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(BITS_PER_WORD) - 64'd1) / 64'(BITS_PER_WORD));
    localparam logic [BITS_PER_WORD-1:0] WORD_ONE = BITS_PER_WORD'(1);

    typedef logic [BITS_PER_WORD-1:0] word_t;

    // control state
    logic [FIU_W-1:0] fiu_reg;
    logic [WORDS-1:0] valid_reg;
    logic             chk_valid_reg;

    // payload
    fba_req_t         item_reg;
    logic [WA-1:0]    issue_w_reg;
    logic [BASE_W-1:0] issue_base_reg;
    logic [WA-1:0]    chk_w_reg;
    logic [BASE_W-1:0] chk_base_reg;
    logic [WA-1:0]    found_w_reg;
    logic [BASE_W-1:0] found_base_reg;
    logic [WB-1:0]    found_bit_reg;
    word_t            found_word_reg;
    logic [WA-1:0]    q_reg;
    logic [WB-1:0]    r_reg;
    logic             rd_valid_reg;
    logic             used_bit_reg;
    fba_rsp_t         res_reg;
    fba_rsp_t         res_next;

    word_t            rd_data;
    word_t            eff_word;
    logic [WB-1:0]    low_bit;
    logic [CMP_W-1:0] base_plus;
    logic             can_issue;
    logic             hit;
    logic             issue_fire;
    logic             rd_en;
    logic [WA-1:0]    rd_addr;
    logic             wr_en;
    logic [WA-1:0]    wr_addr;
    word_t            wr_data;
    logic             pf_in_map;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [31:0]      word_start;
    logic [PF_W-1:0]  rem_full;
    logic [31:0]      frame_sum;

    // words that were never written read as all free
    assign eff_word = rd_valid_reg ? rd_data : '0;

    always_comb begin
        low_bit = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (!eff_word[i]) begin
                low_bit = WB'(i);
            end
        end
    end

    assign base_plus  = CMP_W'(issue_base_reg) + CMP_W'(BITS_PER_WORD);
    assign can_issue  = (base_plus <= CMP_W'(fiu_reg)) && (base_plus <= CMP_W'(LIMIT_MAX));
    assign hit        = chk_valid_reg && (eff_word != '1);
    assign issue_fire = cmd.scan_step && can_issue && !hit;
    assign rd_en      = issue_fire || cmd.fetch;
    assign rd_addr    = cmd.fetch ? q_reg : issue_w_reg;
    assign pf_in_map  = (32'(item_reg.page_frame) < 32'(FRAME_COUNT));

    // frame -> word by reciprocal multiply, exact over the 12-bit range
    assign prod       = PROD_W'(item_reg.page_frame) * PROD_W'(RECIP);
    assign quot       = prod >> SHIFT;
    assign word_start = 32'(q_reg) * 32'(BITS_PER_WORD);
    assign rem_full   = item_reg.page_frame - word_start[PF_W-1:0];
    assign frame_sum  = 32'(found_base_reg) + 32'(found_bit_reg);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = found_w_reg;
        wr_data = found_word_reg | (WORD_ONE << found_bit_reg);
        if (cmd.wr_alloc) begin
            wr_en = 1'b1;
        end else if (cmd.wr_free) begin
            wr_en   = 1'b1;
            wr_addr = q_reg;
            wr_data = eff_word & ~(WORD_ONE << r_reg);
        end
    end

    fba_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (WORDS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg       <= FIU_RESET;
            valid_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fiu_reg <= cfg_wr_data;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.scan_start) begin
                chk_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                chk_valid_reg <= issue_fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.scan_start) begin
            issue_w_reg    <= '0;
            issue_base_reg <= '0;
        end
        if (cmd.scan_step && hit) begin
            found_w_reg    <= chk_w_reg;
            found_base_reg <= chk_base_reg;
            found_bit_reg  <= low_bit;
            found_word_reg <= eff_word;
        end
        if (issue_fire) begin
            chk_w_reg      <= issue_w_reg;
            chk_base_reg   <= issue_base_reg;
            issue_w_reg    <= issue_w_reg + WA'(1);
            issue_base_reg <= issue_base_reg + BASE_W'(BITS_PER_WORD);
        end
        if (cmd.div_step) begin
            q_reg <= quot[WA-1:0];
        end
        if (cmd.fetch) begin
            r_reg <= rem_full[WB-1:0];
        end
        if (rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (cmd.sample_bit) begin
            used_bit_reg <= eff_word[r_reg];
        end
        if (cmd.res_load) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        res_next = '0;
        case (cmd.res_kind)
            RES_ALLOC: begin
                res_next.status      = ST_DONE;
                res_next.frame_index = frame_sum[PF_W-1:0];
                res_next.present     = 1'b1;
                res_next.writeable   = item_reg.write_access;
                res_next.user_mode   = ~item_reg.kernel_access;
            end
            RES_FULL: begin
                res_next.status = ST_FULL;
            end
            RES_FREE: begin
                res_next.status = ST_DONE;
            end
            RES_TEST: begin
                res_next.status      = ST_DONE;
                res_next.frame_index = item_reg.page_frame;
                res_next.frame_used  = pf_in_map && used_bit_reg;
            end
            RES_HELD: begin
                res_next.status      = ST_IDLE;
                res_next.frame_index = item_reg.page_frame;
            end
            default: begin
                res_next.status = ST_IDLE;
            end
        endcase
    end

    assign m_data         = res_reg;
    assign stat.cmd       = item_reg.cmd;
    assign stat.pf_zero   = (item_reg.page_frame == '0);
    assign stat.pf_in_map = pf_in_map;
    assign stat.hit       = hit;
    assign stat.scan_done = !chk_valid_reg && !can_issue;

endmodule

// ===== hdl/fba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ctrl: request sequencer of the frame bitmap allocator
// Decodes each request, steps the datapath through scan, read or
// read-modify-write, and owns the response valid flag.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  fba_pkg::fba_stat_t stat,
    output fba_pkg::fba_cmd_t  cmd
);

    import fba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ALLOC_WR,
        S_DIV,
        S_FETCH,
        S_MODIFY,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      m_valid_reg, m_valid_next;
    logic      slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                case (stat.cmd)
                    CMD_ALLOC: begin
                        if (stat.pf_zero) begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end else begin
                            kind_next = RES_HELD;
                        end
                    end
                    CMD_FREE: begin
                        if (stat.pf_zero) begin
                            kind_next = RES_NONE;
                        end else begin
                            kind_next = RES_FREE;
                            if (stat.pf_in_map) begin
                                state_next = S_DIV;
                            end
                        end
                    end
                    CMD_TEST: begin
                        kind_next = RES_TEST;
                        if (stat.pf_in_map) begin
                            state_next = S_DIV;
                        end
                    end
                    default: begin
                        kind_next = RES_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    state_next = S_ALLOC_WR;
                end else if (stat.scan_done) begin
                    kind_next  = RES_FULL;
                    state_next = S_FINISH;
                end
            end
            S_ALLOC_WR: begin
                cmd.wr_alloc = 1'b1;
                kind_next    = RES_ALLOC;
                state_next   = S_FINISH;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = S_FETCH;
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY: begin
                cmd.sample_bit = 1'b1;
                cmd.wr_free    = (kind_reg == RES_FREE);
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (slot_free) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            kind_reg    <= RES_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule
